// File: rtl/core/stxd_pkg.sv
package stxd_pkg;

    localparam int unsigned CFG_INDEX_W  = 2;
    localparam int unsigned CFG_DATA_W   = 32;
    localparam int unsigned BODY_COUNT_W = 17;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRC_ENABLE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT     = 2'd2;

    localparam logic [7:0]  START_BYTE_RESET = 8'h02;
    localparam logic [31:0] IDLE_MAX         = 32'hFFFF_FFFF;
    localparam logic [BODY_COUNT_W-1:0] CRC_BYTES = BODY_COUNT_W'(2);

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [2:0] POS_COMMAND  = 3'd0;
    localparam logic [2:0] POS_LEN_LOW  = 3'd1;
    localparam logic [2:0] POS_LEN_HIGH = 3'd2;
    localparam logic [2:0] POS_PAYLOAD  = 3'd3;
    localparam logic [2:0] POS_CRC      = 3'd4;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] position;
        logic       last;
        logic       timed_out;
    } result_t;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic        crc_trailer_enable;
        logic [31:0] timeout_ticks;
    } cfg_t;

endpackage

// File: rtl/core/stx_length_prefixed_deframer.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+----------------------------------------
// input    | in_valid / in_ready   | kind, data_byte
// output   | out_valid / out_ready | out_byte, position, last, timed_out
// config   | cfg_we (no wait)      | cfg_index, cfg_data
//
// One item per cycle: the parse state and the output register both load at
// the accept edge, so any result shows on out_valid in the next cycle.
// in_ready is high while the output register is empty or being drained, so
// a stalled consumer stalls the input after one held result.
// Reset clears the parse state to hunting and loads register defaults.
module stx_length_prefixed_deframer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                kind,
    input  logic [7:0]                          data_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [7:0]                          out_byte,
    output logic [2:0]                          position,
    output logic                                last,
    output logic                                timed_out,
    input  logic                                cfg_we,
    input  logic [stxd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [stxd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import stxd_pkg::*;

    cfg_t    cfg_reg;
    logic    accept;
    logic    res_valid;
    result_t res;
    result_t out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte         <= START_BYTE_RESET;
            cfg_reg.crc_trailer_enable <= 1'b0;
            cfg_reg.timeout_ticks      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_BYTE: cfg_reg.start_byte         <= cfg_data[7:0];
                CFG_CRC_ENABLE: cfg_reg.crc_trailer_enable <= cfg_data[0];
                CFG_TIMEOUT:    cfg_reg.timeout_ticks      <= cfg_data[31:0];
                default:        cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    assign accept = in_valid && in_ready;

    stxd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .accept    (accept),
        .kind      (kind),
        .data_byte (data_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    stxd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .load_data (res),
        .can_load  (in_ready),
        .valid     (out_valid),
        .ready     (out_ready),
        .data      (out_data)
    );

    assign out_byte  = out_data.out_byte;
    assign position  = out_data.position;
    assign last      = out_data.last;
    assign timed_out = out_data.timed_out;

endmodule

// File: rtl/core/stxd_parser.sv
module stxd_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  stxd_pkg::cfg_t    cfg,
    input  logic              accept,
    input  logic              kind,
    input  logic [7:0]        data_byte,
    output logic              res_valid,
    output stxd_pkg::result_t res
);
    import stxd_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEADER,
        PH_BODY
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [1:0]              hdr_idx_reg, hdr_idx_next;
    logic [7:0]              len_low_reg, len_low_next;
    logic [BODY_COUNT_W-1:0] bytes_left_reg, bytes_left_next;
    logic [31:0]             idle_reg, idle_next;
    logic                    crc_active_reg, crc_active_next;

    logic [31:0]             idle_inc;
    logic [BODY_COUNT_W-1:0] frame_total;

    always_comb
    begin
        phase_next      = phase_reg;
        hdr_idx_next    = hdr_idx_reg;
        len_low_next    = len_low_reg;
        bytes_left_next = bytes_left_reg;
        idle_next       = idle_reg;
        crc_active_next = crc_active_reg;
        res_valid       = 1'b0;
        res             = '0;
        idle_inc        = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 32'd1;
        frame_total     = {1'b0, data_byte, len_low_reg}
                          + (cfg.crc_trailer_enable ? CRC_BYTES : '0);

        if (accept)
        begin
            if (kind == KIND_TICK)
            begin
                if (phase_reg != PH_HUNT)
                begin
                    idle_next = idle_inc;
                    if (cfg.timeout_ticks != '0 && idle_inc >= cfg.timeout_ticks)
                    begin
                        res_valid       = 1'b1;
                        res.last        = 1'b1;
                        res.timed_out   = 1'b1;
                        phase_next      = PH_HUNT;
                        hdr_idx_next    = '0;
                        len_low_next    = '0;
                        bytes_left_next = '0;
                        idle_next       = '0;
                        crc_active_next = 1'b0;
                    end
                end
            end
            else
            begin
                case (phase_reg)
                    PH_HUNT:
                    begin
                        if (data_byte == cfg.start_byte)
                        begin
                            phase_next      = PH_HEADER;
                            hdr_idx_next    = '0;
                            len_low_next    = '0;
                            bytes_left_next = '0;
                            idle_next       = '0;
                            crc_active_next = 1'b0;
                        end
                    end
                    PH_HEADER:
                    begin
                        idle_next    = '0;
                        res_valid    = 1'b1;
                        res.out_byte = data_byte;
                        case (hdr_idx_reg)
                            2'd0:
                            begin
                                res.position = POS_COMMAND;
                                hdr_idx_next = 2'd1;
                            end
                            2'd1:
                            begin
                                res.position = POS_LEN_LOW;
                                len_low_next = data_byte;
                                hdr_idx_next = 2'd2;
                            end
                            default:
                            begin
                                // length high byte closes the header; latch trailer mode
                                res.position    = POS_LEN_HIGH;
                                crc_active_next = cfg.crc_trailer_enable;
                                hdr_idx_next    = '0;
                                if (frame_total == '0)
                                begin
                                    res.last        = 1'b1;
                                    phase_next      = PH_HUNT;
                                    len_low_next    = '0;
                                    bytes_left_next = '0;
                                    crc_active_next = 1'b0;
                                end
                                else
                                begin
                                    phase_next      = PH_BODY;
                                    bytes_left_next = frame_total;
                                end
                            end
                        endcase
                    end
                    PH_BODY:
                    begin
                        idle_next       = '0;
                        res_valid       = 1'b1;
                        res.out_byte    = data_byte;
                        res.position    = (crc_active_reg && bytes_left_reg <= CRC_BYTES)
                                          ? POS_CRC : POS_PAYLOAD;
                        bytes_left_next = bytes_left_reg - BODY_COUNT_W'(1);
                        if (bytes_left_reg == BODY_COUNT_W'(1))
                        begin
                            res.last        = 1'b1;
                            phase_next      = PH_HUNT;
                            hdr_idx_next    = '0;
                            len_low_next    = '0;
                            bytes_left_next = '0;
                            crc_active_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            hdr_idx_reg    <= '0;
            len_low_reg    <= '0;
            bytes_left_reg <= '0;
            idle_reg       <= '0;
            crc_active_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            hdr_idx_reg    <= hdr_idx_next;
            len_low_reg    <= len_low_next;
            bytes_left_reg <= bytes_left_next;
            idle_reg       <= idle_next;
            crc_active_reg <= crc_active_next;
        end
    end

    a_timeout_report: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.timed_out) |-> (res.last && res.out_byte == '0))
        else $error("timeout report malformed");

    a_hunt_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HUNT) |-> (idle_reg == '0 && bytes_left_reg == '0))
        else $error("hunt state holds stale counters");

    a_body_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (bytes_left_reg != '0))
        else $error("body state with no bytes left");

    a_last_returns_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.last) |=> (phase_reg == PH_HUNT))
        else $error("frame end did not return to hunting");

endmodule

// File: rtl/core/stxd_out_reg.sv
module stxd_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  stxd_pkg::result_t load_data,
    output logic              can_load,
    output logic              valid,
    input  logic              ready,
    output stxd_pkg::result_t data
);
    import stxd_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    // take a new item when nothing is held or when the held one leaves in this cycle
    assign can_load   = !valid_reg || ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> can_load)
        else $error("result loaded over an undelivered item");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg)
        else $error("loaded result not presented");

    a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && ready && !load) |=> !valid_reg)
        else $error("delivered item presented again");

endmodule
